/* rtl/core/qsbs_pkg.sv */
// Shared types and constants of the quicksort batch sorter.
`default_nettype none
package qsbs_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef logic [3:0] qsbs_op_t;

  localparam qsbs_op_t OP_NONE        = 4'd0;
  localparam qsbs_op_t OP_LOAD        = 4'd1;
  localparam qsbs_op_t OP_INIT        = 4'd2;
  localparam qsbs_op_t OP_POP         = 4'd3;
  localparam qsbs_op_t OP_LATCH_RANGE = 4'd4;
  localparam qsbs_op_t OP_RANGE       = 4'd5;
  localparam qsbs_op_t OP_PIVOT       = 4'd6;
  localparam qsbs_op_t OP_SCANL_STEP  = 4'd7;
  localparam qsbs_op_t OP_SCANL_STOP  = 4'd8;
  localparam qsbs_op_t OP_SCANH_STEP  = 4'd9;
  localparam qsbs_op_t OP_SWAP1       = 4'd10;
  localparam qsbs_op_t OP_SWAP2       = 4'd11;
  localparam qsbs_op_t OP_PUSH1       = 4'd12;
  localparam qsbs_op_t OP_PUSH2       = 4'd13;
  localparam qsbs_op_t OP_OUT_RD      = 4'd14;
  localparam qsbs_op_t OP_OUT_LOAD    = 4'd15;

  typedef struct packed {
    qsbs_op_t op;
  } qsbs_cmd_t;

  typedef struct packed {
    logic sp_zero;
    logic range_empty;
    logic a_lt_pivot;
    logic pivot_lt_b;
    logic l_ge_h;
    logic out_last;
  } qsbs_status_t;

endpackage
`default_nettype wire

/* rtl/core/qsbs_if.sv */
// Input and output channel interfaces of the quicksort batch sorter.
`default_nettype none
interface qsbs_in_if;
  import qsbs_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  logic   last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface qsbs_out_if;
  import qsbs_pkg::*;
  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   end_of_batch;
  modport source (output valid, output sorted_value, output end_of_batch, input ready);
  modport sink (input valid, input sorted_value, input end_of_batch, output ready);
endinterface
`default_nettype wire

/* rtl/core/qsbs_datapath.sv */
// Datapath of the quicksort batch sorter: element store, range stack and partition registers.
`default_nettype none
module qsbs_datapath
  import qsbs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire          clk,
  input  wire          rst_n,
  input  qsbs_cmd_t    cmd,
  input  value_t       in_value,
  output qsbs_status_t status,
  output value_t       out_value,
  output logic         out_end
);

  localparam int IDX_W     = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int STK_DEPTH = CAPACITY;
  localparam int ENT_W     = 2 * IDX_W;

  value_t             store_mem [CAPACITY];
  logic [ENT_W-1:0]   stack_mem [STK_DEPTH];

  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   sp_r;
  logic [CNT_W-1:0]   k_r;
  logic [IDX_W-1:0]   lo_r, hi_r, l_r, h_r;
  value_t             pivot_r, a_r, b_r;
  value_t             rd_data_r;
  logic [ENT_W-1:0]   stk_rd_r;
  value_t             out_value_r;
  logic               out_end_r;

  logic [IDX_W-1:0]   mid_idx, l_inc, h_dec, h_inc, left_size, right_size;
  logic [CNT_W-1:0]   sp_dec, k_inc, count_m1;
  logic               big_left, count_room, stack_room, count_ge2;
  logic [ENT_W-1:0]   ent_first, ent_second;

  logic               st_we;
  logic [IDX_W-1:0]   st_wr_addr, st_rd_addr;
  value_t             st_wr_data;
  logic               stk_we;
  logic [IDX_W-1:0]   stk_wr_addr;
  logic [ENT_W-1:0]   stk_wr_data;

  assign mid_idx    = lo_r + ((hi_r - lo_r) >> 1);
  assign l_inc      = l_r + 1'b1;
  assign h_dec      = h_r - 1'b1;
  assign h_inc      = h_r + 1'b1;
  assign left_size  = h_r - lo_r;
  assign right_size = hi_r - h_r - 1'b1;
  assign big_left   = left_size >= right_size;
  assign ent_first  = big_left ? {lo_r, h_r} : {h_inc, hi_r};
  assign ent_second = big_left ? {h_inc, hi_r} : {lo_r, h_r};
  assign sp_dec     = sp_r - 1'b1;
  assign k_inc      = k_r + 1'b1;
  assign count_m1   = count_r - 1'b1;
  assign count_room = count_r < CNT_W'(CAPACITY);
  assign stack_room = sp_r < CNT_W'(STK_DEPTH);
  assign count_ge2  = count_r >= CNT_W'(2);

  always_comb begin
    st_we       = 1'b0;
    st_wr_addr  = h_r;
    st_wr_data  = a_r;
    st_rd_addr  = l_r;
    stk_we      = 1'b0;
    stk_wr_addr = sp_r[IDX_W-1:0];
    stk_wr_data = ent_first;
    unique case (cmd.op)
      OP_LOAD: begin
        st_we      = count_room;
        st_wr_addr = count_r[IDX_W-1:0];
        st_wr_data = in_value;
      end
      OP_INIT: begin
        stk_we      = count_ge2;
        stk_wr_addr = '0;
        stk_wr_data = {IDX_W'(0), count_m1[IDX_W-1:0]};
      end
      OP_RANGE:      st_rd_addr = mid_idx;
      OP_PIVOT:      st_rd_addr = l_r;
      OP_SCANL_STEP: st_rd_addr = l_inc;
      OP_SCANL_STOP: st_rd_addr = h_r;
      OP_SCANH_STEP: st_rd_addr = h_dec;
      OP_SWAP1: begin
        st_we      = 1'b1;
        st_wr_addr = h_r;
        st_wr_data = a_r;
      end
      OP_SWAP2: begin
        st_we      = 1'b1;
        st_wr_addr = l_r;
        st_wr_data = b_r;
        st_rd_addr = l_inc;
      end
      OP_PUSH1: begin
        stk_we      = stack_room;
        stk_wr_data = ent_first;
      end
      OP_PUSH2: begin
        stk_we      = stack_room;
        stk_wr_data = ent_second;
      end
      OP_OUT_RD: st_rd_addr = k_r[IDX_W-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_wr_addr] <= st_wr_data;
    end
    rd_data_r <= store_mem[st_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wr_addr] <= stk_wr_data;
    end
    stk_rd_r <= stack_mem[sp_dec[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sp_r    <= '0;
      k_r     <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: if (count_room) count_r <= count_r + 1'b1;
        OP_INIT: begin
          k_r  <= '0;
          sp_r <= count_ge2 ? CNT_W'(1) : '0;
        end
        OP_POP:   sp_r <= sp_dec;
        OP_PUSH1: if (stack_room) sp_r <= sp_r + 1'b1;
        OP_PUSH2: if (stack_room) sp_r <= sp_r + 1'b1;
        OP_OUT_LOAD: begin
          k_r <= k_inc;
          if (status.out_last) count_r <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LATCH_RANGE: begin
        lo_r <= stk_rd_r[ENT_W-1:IDX_W];
        hi_r <= stk_rd_r[IDX_W-1:0];
      end
      OP_RANGE: begin
        l_r <= lo_r;
        h_r <= hi_r;
      end
      OP_PIVOT:      pivot_r <= rd_data_r;
      OP_SCANL_STEP: l_r <= l_inc;
      OP_SCANL_STOP: a_r <= rd_data_r;
      OP_SCANH_STEP: h_r <= h_dec;
      OP_SWAP1:      b_r <= rd_data_r;
      OP_SWAP2: begin
        l_r <= l_inc;
        h_r <= h_dec;
      end
      OP_OUT_LOAD: begin
        out_value_r <= rd_data_r;
        out_end_r   <= status.out_last;
      end
      default: ;
    endcase
  end

  assign status.sp_zero     = sp_r == '0;
  assign status.range_empty = lo_r >= hi_r;
  assign status.a_lt_pivot  = rd_data_r < pivot_r;
  assign status.pivot_lt_b  = pivot_r < rd_data_r;
  assign status.l_ge_h      = l_r >= h_r;
  assign status.out_last    = k_inc == count_r;

  assign out_value = out_value_r;
  assign out_end   = out_end_r;

endmodule
`default_nettype wire

/* rtl/core/qsbs_ctrl.sv */
// Controller of the quicksort batch sorter: load, partition and drain sequencing.
`default_nettype none
module qsbs_ctrl
  import qsbs_pkg::*;
(
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  input  wire          in_last,
  output logic         in_ready,
  output logic         out_valid,
  input  wire          out_ready,
  input  qsbs_status_t status,
  output qsbs_cmd_t    cmd
);

  localparam logic [3:0] S_LOAD     = 4'd0;
  localparam logic [3:0] S_INIT     = 4'd1;
  localparam logic [3:0] S_POP      = 4'd2;
  localparam logic [3:0] S_POP_WAIT = 4'd3;
  localparam logic [3:0] S_RANGE    = 4'd4;
  localparam logic [3:0] S_PIVOT    = 4'd5;
  localparam logic [3:0] S_SCANL    = 4'd6;
  localparam logic [3:0] S_SCANH    = 4'd7;
  localparam logic [3:0] S_SWAP2    = 4'd8;
  localparam logic [3:0] S_PUSH2    = 4'd9;
  localparam logic [3:0] S_OUT_RD   = 4'd10;
  localparam logic [3:0] S_OUT_LD   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_load;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    in_ready  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (in_last) state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        cmd.op    = OP_INIT;
        state_nxt = S_POP;
      end
      S_POP: begin
        if (status.sp_zero) begin
          state_nxt = S_OUT_RD;
        end else begin
          cmd.op    = OP_POP;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        cmd.op    = OP_LATCH_RANGE;
        state_nxt = S_RANGE;
      end
      S_RANGE: begin
        if (status.range_empty) begin
          state_nxt = S_POP;
        end else begin
          cmd.op    = OP_RANGE;
          state_nxt = S_PIVOT;
        end
      end
      S_PIVOT: begin
        cmd.op    = OP_PIVOT;
        state_nxt = S_SCANL;
      end
      S_SCANL: begin
        if (status.a_lt_pivot) begin
          cmd.op = OP_SCANL_STEP;
        end else begin
          cmd.op    = OP_SCANL_STOP;
          state_nxt = S_SCANH;
        end
      end
      S_SCANH: begin
        priority if (status.pivot_lt_b) begin
          cmd.op = OP_SCANH_STEP;
        end else if (status.l_ge_h) begin
          cmd.op    = OP_PUSH1;
          state_nxt = S_PUSH2;
        end else begin
          cmd.op    = OP_SWAP1;
          state_nxt = S_SWAP2;
        end
      end
      S_SWAP2: begin
        cmd.op    = OP_SWAP2;
        state_nxt = S_SCANL;
      end
      S_PUSH2: begin
        cmd.op    = OP_PUSH2;
        state_nxt = S_POP;
      end
      S_OUT_RD: begin
        cmd.op    = OP_OUT_RD;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        if (!out_valid_r || out_ready) begin
          cmd.op    = OP_OUT_LOAD;
          out_load  = 1'b1;
          state_nxt = status.out_last ? S_LOAD : S_OUT_RD;
        end else begin
          cmd.op = OP_OUT_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // output register: refilled on load, emptied when taken
  always_comb begin
    priority if (out_load) out_valid_nxt = 1'b1;
    else if (out_ready)    out_valid_nxt = 1'b0;
    else                   out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/core/quicksort_batch_sorter_core.sv */
// Top level of the quicksort batch sorter.
//
// Usage: a batch of signed 32-bit values enters on in_ch, one request per
// cycle while in_ch.ready is high; the request with last set closes the
// batch. Up to CAPACITY values are kept, later ones are dropped, though a
// last mark still closes the batch.
// The batch is then sorted in place (Hoare partition, middle pivot, range
// stack in a small memory) and in_ch.ready stays low until the sorted
// values have been handed to the output register.
// The sort is paced by the single read port of the element store. Once the
// sort completes, draining reads each result from the store and then loads
// it into the output register, one result at a time.
// out_ch carries the values in ascending order; end_of_batch marks the
// final one. A stalled receiver holds the output register and the drain
// waits. Once the final result sits in the register, loading of the
// next batch starts. Reset is synchronous: the block comes up empty and
// ready to load; the memories need no clearing.
`default_nettype none
module quicksort_batch_sorter_core
  import qsbs_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input wire         clk,
  input wire         rst_n,
  qsbs_in_if.sink    in_ch,
  qsbs_out_if.source out_ch
);

  qsbs_cmd_t    cmd;
  qsbs_status_t status;

  qsbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  qsbs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_ch.value),
    .status    (status),
    .out_value (out_ch.sorted_value),
    .out_end   (out_ch.end_of_batch)
  );

endmodule
`default_nettype wire
